/* hw/rtl/telnet_rx_option_parser_unit_macros.svh */
// Assertion macros for the telnet receive parser RTL.
`ifndef TELNET_RX_OPTION_PARSER_UNIT_MACROS_SVH
`define TELNET_RX_OPTION_PARSER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, disabled while reset is asserted.
`define TNRX_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error("tnrx assertion failed");

// Clocked check that also holds during reset.
`define TNRX_ASSERT_ALWAYS(lbl, clk_s, prop) \
	lbl: assert property (@(posedge clk_s) prop) \
		else $error("tnrx assertion failed");

`else

`define TNRX_ASSERT(lbl, clk_s, rst_n_s, prop)
`define TNRX_ASSERT_ALWAYS(lbl, clk_s, prop)

`endif

`endif

/* hw/rtl/tnrx_pkg.sv */
package tnrx_pkg;

	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO   = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB   = 8'd250;
	localparam logic [7:0] B_SE   = 8'd240;
	localparam logic [7:0] B_ESC  = 8'h1B;

	localparam logic [7:0] OPT_ECHO = 8'd1;
	localparam logic [7:0] OPT_SGA  = 8'd3;
	localparam logic [7:0] OPT_NAWS = 8'd31;

	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SS3    = 8'h4F;
	localparam logic [7:0] CH_UP     = 8'h41;
	localparam logic [7:0] CH_DOWN   = 8'h42;
	localparam logic [7:0] CH_RIGHT  = 8'h43;
	localparam logic [7:0] CH_LEFT   = 8'h44;
	localparam logic [7:0] CH_END    = 8'h46;
	localparam logic [7:0] CH_HOME   = 8'h48;
	localparam logic [7:0] CH_1      = 8'h31;
	localparam logic [7:0] CH_2      = 8'h32;
	localparam logic [7:0] CH_3      = 8'h33;
	localparam logic [7:0] CH_4      = 8'h34;
	localparam logic [7:0] CH_5      = 8'h35;
	localparam logic [7:0] CH_6      = 8'h36;

	localparam logic [7:0] KEY_HOME = 8'h01;
	localparam logic [7:0] KEY_END  = 8'h05;

	localparam logic [2:0] SUB_FULL = 3'd5;

	localparam logic [15:0] DEFAULT_COLS = 16'd80;
	localparam logic [15:0] DEFAULT_ROWS = 16'd24;

	typedef enum logic [0:0] {
		REG_DEFAULT_COLS = 1'b0,
		REG_DEFAULT_ROWS = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		M_NORMAL  = 3'd0,
		M_CMD     = 3'd1,
		M_VERB    = 3'd2,
		M_SUB     = 3'd3,
		M_SUB_IAC = 3'd4,
		M_ESC     = 3'd5,
		M_SEQ     = 3'd6,
		M_SKIP    = 3'd7
	} mode_t;

	typedef enum logic [3:0] {
		KIND_KEY     = 4'd0,
		KIND_UP      = 4'd1,
		KIND_DOWN    = 4'd2,
		KIND_RIGHT   = 4'd3,
		KIND_LEFT    = 4'd4,
		KIND_REFUSE  = 4'd5,
		KIND_WINSIZE = 4'd6,
		KIND_REQ_OFF = 4'd7,
		KIND_DELETE  = 4'd8
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  key;
		logic [7:0]  verb;
		logic [7:0]  opt;
		logic [15:0] cols;
		logic [15:0] rows;
	} evt_t;

endpackage

/* hw/rtl/tnrx_in_reg.sv */
module tnrx_in_reg
	import tnrx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	input  logic       take
);

	logic valid_q;
	logic [7:0] byte_q;

	assign in_ready = !valid_q || take;
	assign valid_s1 = valid_q;
	assign byte_s1  = byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_q <= in_byte;
		end
	end

endmodule

/* hw/rtl/tnrx_parser.sv */
`include "telnet_rx_option_parser_unit_macros.svh"

module tnrx_parser
	import tnrx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  reg_idx_t    cfg_idx,
	input  logic [15:0] cfg_wdata,
	input  logic        valid_s1,
	input  logic [7:0]  byte_s1,
	input  logic        advance,
	output logic        emit,
	output evt_t        evt
);

	logic [15:0] def_cols_q;
	logic [15:0] def_rows_q;

	mode_t       mode_q, mode_d;
	logic [7:0]  verb_q, verb_d;
	logic [7:0]  sub_opt_q, sub_opt_d;
	logic [2:0]  sub_cnt_q, sub_cnt_d;
	logic [7:0]  sub_bytes_q [4];
	logic [7:0]  sub_bytes_d [4];

	logic        emit_raw;
	logic        refused;
	logic [2:0]  cnt_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_cols_q <= DEFAULT_COLS;
			def_rows_q <= DEFAULT_ROWS;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DEFAULT_COLS: def_cols_q <= cfg_wdata;
				REG_DEFAULT_ROWS: def_rows_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign refused = (verb_q == B_WONT) || (verb_q == B_DONT);
	assign cnt_m1  = sub_cnt_q - 3'd1;

	always_comb begin
		mode_d      = mode_q;
		verb_d      = verb_q;
		sub_opt_d   = sub_opt_q;
		sub_cnt_d   = sub_cnt_q;
		sub_bytes_d = sub_bytes_q;
		emit_raw    = 1'b0;
		evt         = '0;
		evt.kind    = KIND_KEY;
		unique case (mode_q)
			M_CMD: begin
				priority if (byte_s1 == B_DO || byte_s1 == B_DONT ||
						byte_s1 == B_WILL || byte_s1 == B_WONT) begin
					verb_d = byte_s1;
					mode_d = M_VERB;
				end else if (byte_s1 == B_SB) begin
					sub_cnt_d = 3'd0;
					mode_d    = M_SUB;
				end else begin
					mode_d = M_NORMAL;
					if (byte_s1 == B_IAC) begin
						emit_raw = 1'b1;
						evt.key  = B_IAC;
					end
				end
			end
			M_VERB: begin
				mode_d = M_NORMAL;
				priority if (byte_s1 == OPT_ECHO || byte_s1 == OPT_SGA) begin
					if (refused) begin
						emit_raw = 1'b1;
						evt.kind = KIND_REQ_OFF;
						evt.opt  = byte_s1;
					end
				end else if (byte_s1 == OPT_NAWS) begin
					if (refused) begin
						emit_raw = 1'b1;
						evt.kind = KIND_WINSIZE;
						evt.cols = def_cols_q;
						evt.rows = def_rows_q;
					end
				end else if (verb_q == B_DO) begin
					emit_raw = 1'b1;
					evt.kind = KIND_REFUSE;
					evt.verb = B_WONT;
					evt.opt  = byte_s1;
				end else if (verb_q == B_WILL) begin
					emit_raw = 1'b1;
					evt.kind = KIND_REFUSE;
					evt.verb = B_DONT;
					evt.opt  = byte_s1;
				end else begin
				end
			end
			M_SUB, M_SUB_IAC: begin
				if (mode_q == M_SUB && byte_s1 == B_IAC) begin
					mode_d = M_SUB_IAC;
				end else if (mode_q == M_SUB_IAC && byte_s1 == B_SE) begin
					mode_d = M_NORMAL;
					if (sub_cnt_q == SUB_FULL && sub_opt_q == OPT_NAWS) begin
						emit_raw = 1'b1;
						evt.kind = KIND_WINSIZE;
						evt.cols = {sub_bytes_q[0], sub_bytes_q[1]};
						evt.rows = {sub_bytes_q[2], sub_bytes_q[3]};
					end
				end else begin
					mode_d = M_SUB;
					if (sub_cnt_q == 3'd0) begin
						sub_opt_d = byte_s1;
						sub_cnt_d = 3'd1;
					end else if (sub_cnt_q < SUB_FULL) begin
						sub_bytes_d[cnt_m1[1:0]] = byte_s1;
						sub_cnt_d = sub_cnt_q + 3'd1;
					end
				end
			end
			M_ESC: begin
				mode_d = (byte_s1 == CH_LBRACK || byte_s1 == CH_SS3) ? M_SEQ : M_NORMAL;
			end
			M_SEQ: begin
				mode_d = M_NORMAL;
				unique case (byte_s1)
					CH_UP: begin
						emit_raw = 1'b1;
						evt.kind = KIND_UP;
					end
					CH_DOWN: begin
						emit_raw = 1'b1;
						evt.kind = KIND_DOWN;
					end
					CH_RIGHT: begin
						emit_raw = 1'b1;
						evt.kind = KIND_RIGHT;
					end
					CH_LEFT: begin
						emit_raw = 1'b1;
						evt.kind = KIND_LEFT;
					end
					CH_END: begin
						emit_raw = 1'b1;
						evt.key  = KEY_END;
					end
					CH_HOME: begin
						emit_raw = 1'b1;
						evt.key  = KEY_HOME;
					end
					CH_1: begin
						mode_d   = M_SKIP;
						emit_raw = 1'b1;
						evt.key  = KEY_HOME;
					end
					CH_3: begin
						mode_d   = M_SKIP;
						emit_raw = 1'b1;
						evt.kind = KIND_DELETE;
					end
					CH_4: begin
						mode_d   = M_SKIP;
						emit_raw = 1'b1;
						evt.key  = KEY_END;
					end
					CH_2, CH_5, CH_6: begin
						mode_d = M_SKIP;
					end
					default: ;
				endcase
			end
			M_SKIP: begin
				mode_d = M_NORMAL;
			end
			M_NORMAL: begin
				priority if (byte_s1 == B_IAC) begin
					mode_d = M_CMD;
				end else if (byte_s1 == B_ESC) begin
					mode_d = M_ESC;
				end else begin
					emit_raw = 1'b1;
					evt.key  = byte_s1;
				end
			end
			default: ;
		endcase
	end

	assign emit = valid_s1 && emit_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_NORMAL;
			verb_q      <= 8'd0;
			sub_opt_q   <= 8'd0;
			sub_cnt_q   <= 3'd0;
			sub_bytes_q <= '{default: 8'd0};
		end else if (advance) begin
			mode_q      <= mode_d;
			verb_q      <= verb_d;
			sub_opt_q   <= sub_opt_d;
			sub_cnt_q   <= sub_cnt_d;
			sub_bytes_q <= sub_bytes_d;
		end
	end

	`TNRX_ASSERT_ALWAYS(a_sub_cnt_bound, clk, sub_cnt_q <= SUB_FULL)
	`TNRX_ASSERT(a_skip_returns, clk, arst_n, (advance && mode_q == M_SKIP) |=> mode_q == M_NORMAL)
	`TNRX_ASSERT(a_advance_valid, clk, arst_n, advance |-> valid_s1)
	`TNRX_ASSERT(a_silent_modes, clk, arst_n, (mode_q == M_ESC || mode_q == M_SKIP || mode_q == M_SUB) |-> !emit)
	`TNRX_ASSERT(a_state_holds, clk, arst_n, !$past(advance) |-> $stable(mode_q))

endmodule

/* hw/rtl/tnrx_out_reg.sv */
module tnrx_out_reg
	import tnrx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  evt_t evt,
	output logic free,
	output logic out_valid,
	input  logic out_ready,
	output evt_t out_evt
);

	logic valid_q;
	evt_t evt_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_evt   = evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			evt_q <= evt;
		end
	end

endmodule

/* hw/rtl/telnet_rx_option_parser_unit.sv */
// Telnet receive parser: one received byte in, at most one event out.
// Input channel: rx_valid / rx_ready with rx_byte. Output channel:
// event_valid / event_ready with event_kind, key_code, reply_verb,
// option_code, win_cols and win_rows; fields unused by a kind read zero.
// Config: write cfg_wdata to default_cols (cfg_addr 0) or default_rows
// (cfg_addr 1) with cfg_we, only while no byte is in flight.
// A byte accepted into the input register is parsed and its event is
// loaded into the output register (one input register, one parse stage).
// Throughput: one byte per cycle while the output register is free; the
// parse state update is a single short step, so bytes follow back to back.
// Bytes that produce no event (IAC, ESC, option verbs, subnegotiation
// data) still pass the parse stage and leave no beat on the output.
// Reset clears the parse state to normal data mode, sets the default
// window size to 80 x 24 and empties both registers.
// When event_ready is low, the finished event holds; the input register
// takes at most one more byte, after which rx_ready drops until it drains.
module telnet_rx_option_parser_unit
	import tnrx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata,
	output logic        event_valid,
	input  logic        event_ready,
	output logic [3:0]  event_kind,
	output logic [7:0]  key_code,
	output logic [7:0]  reply_verb,
	output logic [7:0]  option_code,
	output logic [15:0] win_cols,
	output logic [15:0] win_rows
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       out_free;
	logic       emit;
	evt_t       evt;
	evt_t       out_evt;

	assign advance = valid_s1 && out_free;

	tnrx_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx_valid),
		.in_ready (rx_ready),
		.in_byte  (rx_byte),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.take     (advance)
	);

	tnrx_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (reg_idx_t'(cfg_addr)),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.advance   (advance),
		.emit      (emit),
		.evt       (evt)
	);

	tnrx_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.evt       (evt),
		.free      (out_free),
		.out_valid (event_valid),
		.out_ready (event_ready),
		.out_evt   (out_evt)
	);

	assign event_kind  = 4'(out_evt.kind);
	assign key_code    = out_evt.key;
	assign reply_verb  = out_evt.verb;
	assign option_code = out_evt.opt;
	assign win_cols    = out_evt.cols;
	assign win_rows    = out_evt.rows;

endmodule

/* bench/tb_telnet_rx_option_parser_unit.sv */
`timescale 1ns / 1ps

module tb_telnet_rx_option_parser_unit;
	import tnrx_pkg::*;

	typedef enum bit [1:0] {
		ROW_MODEL,
		ROW_SILENT,
		ROW_EVENT
	} row_check_t;

	typedef struct {
		logic [7:0] b;
		row_check_t chk;
		evt_t       want;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        rx_valid;
	logic        rx_ready;
	logic [7:0]  rx_byte;
	logic        cfg_we;
	logic        cfg_addr;
	logic [15:0] cfg_wdata;
	logic        event_valid;
	logic        event_ready = 1'b0;
	logic [3:0]  event_kind;
	logic [7:0]  key_code;
	logic [7:0]  reply_verb;
	logic [7:0]  option_code;
	logic [15:0] win_cols;
	logic [15:0] win_rows;

	mode_t       pmode;
	logic [7:0]  held_verb;
	logic [7:0]  sb_opt;
	logic [2:0]  sb_cnt;
	logic [7:0]  sb_bytes[4];
	logic [15:0] dflt_cols;
	logic [15:0] dflt_rows;

	evt_t        awaited_events[$];
	logic [7:0]  rx_script[$];
	bit          calm = 1'b0;
	int          errors = 0;

	telnet_rx_option_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.event_valid(event_valid),
		.event_ready(event_ready),
		.event_kind(event_kind),
		.key_code(key_code),
		.reply_verb(reply_verb),
		.option_code(option_code),
		.win_cols(win_cols),
		.win_rows(win_rows)
	);

	always #6 clk = ~clk;

	function automatic evt_t make_evt(input kind_t k, input logic [7:0] key,
			input logic [7:0] verb, input logic [7:0] opt,
			input logic [15:0] cols, input logic [15:0] rows);
		evt_t e;
		e.kind = k;
		e.key  = key;
		e.verb = verb;
		e.opt  = opt;
		e.cols = cols;
		e.rows = rows;
		return e;
	endfunction

	task automatic store_sub_byte(input logic [7:0] b);
		if (sb_cnt == 3'd0) begin
			sb_opt = b;
			sb_cnt = 3'd1;
		end else if (sb_cnt < SUB_FULL) begin
			sb_bytes[2'(sb_cnt - 3'd1)] = b;
			sb_cnt = sb_cnt + 3'd1;
		end
	endtask

	task automatic parse_rx_byte(input logic [7:0] b, output bit fires, output evt_t ev);
		bit refused;
		fires = 1'b0;
		ev = make_evt(KIND_KEY, '0, '0, '0, '0, '0);
		case (pmode)
			M_CMD: begin
				if (b == B_DO || b == B_DONT || b == B_WILL || b == B_WONT) begin
					held_verb = b;
					pmode = M_VERB;
				end else if (b == B_SB) begin
					sb_cnt = 3'd0;
					pmode = M_SUB;
				end else begin
					pmode = M_NORMAL;
					if (b == B_IAC) begin
						fires = 1'b1;
						ev = make_evt(KIND_KEY, B_IAC, '0, '0, '0, '0);
					end
				end
			end
			M_VERB: begin
				pmode = M_NORMAL;
				refused = (held_verb == B_WONT || held_verb == B_DONT);
				if (b == OPT_ECHO || b == OPT_SGA) begin
					fires = refused;
					ev = make_evt(KIND_REQ_OFF, '0, '0, b, '0, '0);
				end else if (b == OPT_NAWS) begin
					fires = refused;
					ev = make_evt(KIND_WINSIZE, '0, '0, '0, dflt_cols, dflt_rows);
				end else if (held_verb == B_DO) begin
					fires = 1'b1;
					ev = make_evt(KIND_REFUSE, '0, B_WONT, b, '0, '0);
				end else if (held_verb == B_WILL) begin
					fires = 1'b1;
					ev = make_evt(KIND_REFUSE, '0, B_DONT, b, '0, '0);
				end
			end
			M_SUB: begin
				if (b == B_IAC)
					pmode = M_SUB_IAC;
				else
					store_sub_byte(b);
			end
			M_SUB_IAC: begin
				if (b == B_SE) begin
					pmode = M_NORMAL;
					if (sb_cnt >= SUB_FULL && sb_opt == OPT_NAWS) begin
						fires = 1'b1;
						ev = make_evt(KIND_WINSIZE, '0, '0, '0, {sb_bytes[0], sb_bytes[1]},
							{sb_bytes[2], sb_bytes[3]});
					end
				end else begin
					pmode = M_SUB;
					store_sub_byte(b);
				end
			end
			M_ESC: begin
				pmode = (b == CH_LBRACK || b == CH_SS3) ? M_SEQ : M_NORMAL;
			end
			M_SEQ: begin
				pmode = M_NORMAL;
				fires = 1'b1;
				case (b)
					CH_UP:    ev = make_evt(KIND_UP, '0, '0, '0, '0, '0);
					CH_DOWN:  ev = make_evt(KIND_DOWN, '0, '0, '0, '0, '0);
					CH_RIGHT: ev = make_evt(KIND_RIGHT, '0, '0, '0, '0, '0);
					CH_LEFT:  ev = make_evt(KIND_LEFT, '0, '0, '0, '0, '0);
					CH_END:   ev = make_evt(KIND_KEY, KEY_END, '0, '0, '0, '0);
					CH_HOME:  ev = make_evt(KIND_KEY, KEY_HOME, '0, '0, '0, '0);
					CH_1: begin
						pmode = M_SKIP;
						ev = make_evt(KIND_KEY, KEY_HOME, '0, '0, '0, '0);
					end
					CH_3: begin
						pmode = M_SKIP;
						ev = make_evt(KIND_DELETE, '0, '0, '0, '0, '0);
					end
					CH_4: begin
						pmode = M_SKIP;
						ev = make_evt(KIND_KEY, KEY_END, '0, '0, '0, '0);
					end
					CH_2, CH_5, CH_6: begin
						pmode = M_SKIP;
						fires = 1'b0;
					end
					default: fires = 1'b0;
				endcase
			end
			M_SKIP: pmode = M_NORMAL;
			default: begin
				if (b == B_IAC) begin
					pmode = M_CMD;
				end else if (b == B_ESC) begin
					pmode = M_ESC;
				end else begin
					fires = 1'b1;
					ev = make_evt(KIND_KEY, b, '0, '0, '0, '0);
				end
			end
		endcase
	endtask

	// Enter and leave at a falling edge; hold the beat until accepted.
	task automatic send_byte(input logic [7:0] b, output bit fires, output evt_t ev);
		while (!calm && $urandom_range(0, 99) < 7) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!rx_ready);
		parse_rx_byte(b, fires, ev);
		@(negedge clk);
	endtask

	task automatic queue_sequence();
		logic [7:0] verbs[4] = '{B_DO, B_DONT, B_WILL, B_WONT};
		logic [7:0] finals[12] = '{CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, CH_END, CH_HOME,
			CH_1, CH_2, CH_3, CH_4, CH_5, CH_6};
		logic [7:0] d;
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				d = 8'($urandom_range(0, 254));
				rx_script.push_back(d == B_ESC ? 8'h20 : d);
			end
		end else if (pick < 30) begin
			rx_script.push_back(B_IAC);
			rx_script.push_back(B_IAC);
		end else if (pick < 50) begin
			rx_script.push_back(B_IAC);
			rx_script.push_back(verbs[$urandom_range(0, 3)]);
			case ($urandom_range(0, 7))
				0: d = OPT_ECHO;
				1: d = OPT_SGA;
				2, 3: d = OPT_NAWS;
				default: d = 8'($urandom_range(0, 255));
			endcase
			rx_script.push_back(d);
		end else if (pick < 55) begin
			rx_script.push_back(B_IAC);
			rx_script.push_back(8'($urandom_range(0, 249)));
		end else if (pick < 72) begin
			rx_script.push_back(B_IAC);
			rx_script.push_back(B_SB);
			rx_script.push_back($urandom_range(0, 4) != 0 ? OPT_NAWS : 8'($urandom_range(0, 254)));
			n = ($urandom_range(0, 9) < 6) ? 4 : $urandom_range(0, 6);
			repeat (n) begin
				d = 8'($urandom_range(0, 255));
				if (d == B_IAC) begin
					rx_script.push_back(B_IAC);
				end else if ($urandom_range(0, 19) == 0) begin
					rx_script.push_back(B_IAC);
					if (d == B_SE)
						d = d + 8'd1;
				end
				rx_script.push_back(d);
			end
			if ($urandom_range(0, 19) != 0) begin
				rx_script.push_back(B_IAC);
				rx_script.push_back(B_SE);
			end
		end else if (pick < 90) begin
			rx_script.push_back(B_ESC);
			if ($urandom_range(0, 9) == 0)
				rx_script.push_back(8'($urandom_range(0, 255)));
			else
				rx_script.push_back($urandom_range(0, 1) ? CH_LBRACK : CH_SS3);
			d = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
				: finals[$urandom_range(0, 11)];
			rx_script.push_back(d);
			if (d >= CH_1 && d <= CH_6)
				rx_script.push_back($urandom_range(0, 1) ? 8'h7E : 8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(1, 3);
			repeat (n)
				rx_script.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : watch_events
		evt_t want;
		if (arst_n && event_valid && event_ready) begin
			if (awaited_events.size() == 0) begin
				$display("%0t: event expected none got kind %0d key %0d", $time,
					event_kind, key_code);
				errors++;
			end else begin
				want = awaited_events.pop_front();
				check_field("event_kind", 16'(want.kind), 16'(event_kind));
				check_field("key_code", 16'(want.key), 16'(key_code));
				check_field("reply_verb", 16'(want.verb), 16'(reply_verb));
				check_field("option_code", 16'(want.opt), 16'(option_code));
				check_field("win_cols", want.cols, win_cols);
				check_field("win_rows", want.rows, win_rows);
			end
		end
	end

	always @(negedge clk)
		event_ready <= calm || ($urandom_range(0, 99) >= 7);

	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		script_row_t script[26];
		evt_t blank;
		evt_t ev;
		bit fires;
		int ph;
		int sent;
		logic [15:0] cols;
		logic [15:0] rows;
		logic [7:0] b;

		arst_n = 1'b0;
		rx_valid = 1'b0;
		rx_byte = 8'h00;
		cfg_we = 1'b0;
		cfg_addr = REG_DEFAULT_COLS;
		cfg_wdata = 16'h0000;

		pmode = M_NORMAL;
		held_verb = 8'h00;
		sb_opt = 8'h00;
		sb_cnt = 3'd0;
		foreach (sb_bytes[i])
			sb_bytes[i] = 8'h00;
		dflt_cols = DEFAULT_COLS;
		dflt_rows = DEFAULT_ROWS;

		blank = make_evt(KIND_KEY, '0, '0, '0, '0, '0);
		script = '{
			'{8'h00, ROW_EVENT, make_evt(KIND_KEY, 8'h00, '0, '0, '0, '0)},
			'{B_IAC, ROW_MODEL, blank},
			'{B_IAC, ROW_EVENT, make_evt(KIND_KEY, B_IAC, '0, '0, '0, '0)},
			'{B_IAC, ROW_MODEL, blank},
			'{B_DO, ROW_SILENT, blank},
			'{8'h05, ROW_EVENT, make_evt(KIND_REFUSE, '0, B_WONT, 8'h05, '0, '0)},
			'{B_IAC, ROW_MODEL, blank},
			'{B_WONT, ROW_MODEL, blank},
			'{OPT_ECHO, ROW_EVENT, make_evt(KIND_REQ_OFF, '0, '0, OPT_ECHO, '0, '0)},
			'{B_IAC, ROW_MODEL, blank},
			'{B_DONT, ROW_MODEL, blank},
			'{OPT_NAWS, ROW_EVENT,
				make_evt(KIND_WINSIZE, '0, '0, '0, DEFAULT_COLS, DEFAULT_ROWS)},
			'{B_IAC, ROW_MODEL, blank},
			'{B_SB, ROW_MODEL, blank},
			'{OPT_NAWS, ROW_MODEL, blank},
			'{8'h00, ROW_MODEL, blank},
			'{B_IAC, ROW_MODEL, blank},
			'{B_IAC, ROW_MODEL, blank},
			'{8'h00, ROW_MODEL, blank},
			'{8'h19, ROW_MODEL, blank},
			'{B_IAC, ROW_MODEL, blank},
			'{B_SE, ROW_EVENT, make_evt(KIND_WINSIZE, '0, '0, '0, 16'h00FF, 16'h0019)},
			'{B_ESC, ROW_MODEL, blank},
			'{CH_SS3, ROW_MODEL, blank},
			'{CH_3, ROW_EVENT, make_evt(KIND_DELETE, '0, '0, '0, '0, '0)},
			'{8'h7E, ROW_SILENT, blank}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			send_byte(script[i].b, fires, ev);
			if (script[i].chk == ROW_MODEL && fires)
				awaited_events.push_back(ev);
			else if (script[i].chk == ROW_EVENT)
				awaited_events.push_back(script[i].want);
		end

		for (ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				while (awaited_events.size() != 0)
					@(negedge clk);
				// drain bytes that leave no beat
				repeat (4) @(negedge clk);
				case (ph)
					1: begin
						cols = 16'd1;
						rows = 16'd1;
					end
					2: begin
						cols = 16'hFFFF;
						rows = 16'hFFFF;
					end
					3: begin
						cols = 16'($urandom_range(1, 65535));
						rows = 16'($urandom_range(1, 65535));
					end
					default: begin
						cols = 16'hFFFF;
						rows = 16'd1;
					end
				endcase
				cfg_we <= 1'b1;
				cfg_addr <= REG_DEFAULT_COLS;
				cfg_wdata <= cols;
				@(negedge clk);
				cfg_addr <= REG_DEFAULT_ROWS;
				cfg_wdata <= rows;
				@(negedge clk);
				cfg_we <= 1'b0;
				dflt_cols = cols;
				dflt_rows = rows;
			end
			calm = (ph == 2);
			sent = 0;
			while (sent < 400) begin
				queue_sequence();
				while (rx_script.size() != 0) begin
					b = rx_script.pop_front();
					send_byte(b, fires, ev);
					if (fires)
						awaited_events.push_back(ev);
					sent++;
				end
			end
			rx_valid <= 1'b0;
		end
		calm = 1'b0;

		while (awaited_events.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
